>>> rtl/core/lkv_pkg.sv
// lkv_pkg: shared types and constants of the LRU key-value cache.
// Depends on nothing; imported by every module of the block except lkv_ram.
`default_nettype none

package lkv_pkg;

   localparam int KEY_FIELD_W   = 16;
   localparam int VALUE_FIELD_W = 32;
   localparam int CAP_W         = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam logic ACT_LOOKUP = 1'b0;
   localparam logic ACT_STORE  = 1'b1;

   typedef struct packed {
      logic                     action;
      logic [KEY_FIELD_W-1:0]   lookup_key;
      logic [VALUE_FIELD_W-1:0] store_value;
   } req_type;

   typedef struct packed {
      logic                     hit;
      logic [VALUE_FIELD_W-1:0] read_value;
      logic                     evicted;
      logic [KEY_FIELD_W-1:0]   evicted_key;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic compare;
      logic read;
      logic commit;
   } lkv_cmd_type;

   typedef struct packed {
      logic rsp_busy;
   } lkv_status_type;

endpackage

`default_nettype wire

>>> rtl/core/lru_key_value_cache_top.sv
// Fully associative key-value cache with least-recently-used replacement.
// Usage:
//   req channel (req_valid/req_ready/req_payload): one lookup or store per
//     transaction. rsp channel (rsp_valid/rsp_ready/rsp_payload): exactly one
//     result per request, in order. csr channel (csr_valid/csr_ready/csr_data)
//     writes the capacity register; write it only while the block is idle.
//   Sequence: the controller steps through accept, key compare across all
//     entries, RAM read and commit; rsp_valid is registered at commit. Only
//     one transaction is in flight: req_ready stays low until its commit.
//   The result sits in an output register, so a stalled rsp side does not
//     block acceptance of the next request; the commit of that next request
//     waits until the previous result is taken.
//   Reset clears all valid marks, ranks, the entry count and the result
//     valid flag, and sets capacity to 16. req_ready rises in the cycle after
//     reset is released. No clearing pass is needed.
// Depends on lkv_pkg, lkv_ctrl, lkv_datapath, lkv_ram.
`default_nettype none

module lru_key_value_cache_top
   import lkv_pkg::*;
#(
   parameter int MAX_ENTRIES = 16,
   parameter int KEY_BITS    = 16,
   parameter int VALUE_BITS  = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire req_type          req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_type               rsp_payload,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [CAP_W-1:0] csr_data
);

   lkv_cmd_type    cmd;
   lkv_status_type status;

   assign csr_ready = 1'b1;

   lkv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lkv_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .KEY_BITS    (KEY_BITS),
      .VALUE_BITS  (VALUE_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

>>> rtl/core/lkv_ram.sv
// lkv_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lkv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/lkv_ctrl.sv
// lkv_ctrl: sequencing state machine of the LRU key-value cache.
// Depends on lkv_pkg; drives the command struct of lkv_datapath.
`default_nettype none

module lkv_ctrl
   import lkv_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire lkv_status_type status,
   output lkv_cmd_type         cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_READ,
      ST_COMMIT
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid && req_ready_ff) begin
                  state_ff     <= ST_COMPARE;
                  req_ready_ff <= 1'b0;
               end else begin
                  req_ready_ff <= 1'b1;
               end
            end
            ST_COMPARE: begin
               state_ff <= ST_READ;
            end
            ST_READ: begin
               state_ff <= ST_COMMIT;
            end
            ST_COMMIT: begin
               if (!status.rsp_busy) begin
                  state_ff     <= ST_IDLE;
                  req_ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff     <= ST_IDLE;
               req_ready_ff <= 1'b0;
            end
         endcase
      end
   end

   assign req_ready   = req_ready_ff;
   assign cmd.load    = req_valid && req_ready_ff;
   assign cmd.compare = (state_ff == ST_COMPARE);
   assign cmd.read    = (state_ff == ST_READ);
   assign cmd.commit  = (state_ff == ST_COMMIT) && !status.rsp_busy;

endmodule

`default_nettype wire

>>> rtl/core/lkv_datapath.sv
// lkv_datapath: key CAM, recency ranks, value and key RAMs, result register.
// Depends on lkv_pkg and lkv_ram; commanded by lkv_ctrl.
`default_nettype none

module lkv_datapath
   import lkv_pkg::*;
#(
   parameter int MAX_ENTRIES = 16,
   parameter int KEY_BITS    = 16,
   parameter int VALUE_BITS  = 32
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire lkv_cmd_type    cmd,
   output lkv_status_type      status,
   input  wire req_type        req_payload,
   input  wire logic           csr_valid,
   input  wire logic [CAP_W-1:0] csr_data,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output rsp_type             rsp_payload
);

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int KEY_W = (KEY_BITS < KEY_FIELD_W) ? KEY_BITS : KEY_FIELD_W;
   localparam int VAL_W = (VALUE_BITS < VALUE_FIELD_W) ? VALUE_BITS : VALUE_FIELD_W;

   // transaction latch
   logic             act_ff;
   logic [KEY_W-1:0] key_ff;
   logic [VAL_W-1:0] val_ff;

   // table state
   logic             valid_ff [MAX_ENTRIES];
   logic             valid_in [MAX_ENTRIES];
   logic [IDX_W-1:0] rank_ff  [MAX_ENTRIES];
   logic [IDX_W-1:0] rank_in  [MAX_ENTRIES];
   logic [KEY_W-1:0] entry_key_ff [MAX_ENTRIES];
   logic [CNT_W-1:0] count_ff;
   logic [CAP_W-1:0] capacity_ff;

   // compare stage results
   logic             hit_ff;
   logic [IDX_W-1:0] hit_idx_ff;
   logic [IDX_W-1:0] hit_rank_ff;
   logic [IDX_W-1:0] slot_idx_ff;
   logic             full_ff;

   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;

   logic [MAX_ENTRIES-1:0] match;
   logic [MAX_ENTRIES-1:0] victim;
   logic [IDX_W-1:0] hit_idx;
   logic [IDX_W-1:0] hit_rank;
   logic [IDX_W-1:0] victim_idx;
   logic [IDX_W-1:0] free_idx;
   logic [CNT_W-1:0] cnt_dec;
   logic [IDX_W-1:0] last_rank;
   logic [31:0]      cap_eff;
   logic             full;

   logic             do_insert;
   logic             evict;
   logic [VAL_W-1:0] val_rdata;
   logic [KEY_W-1:0] key_rdata;

   assign cnt_dec   = count_ff - CNT_W'(1);
   assign last_rank = cnt_dec[IDX_W-1:0];

   always_comb begin
      cap_eff = 32'(capacity_ff);
      if (cap_eff == 32'd0) begin
         cap_eff = 32'd1;
      end else if (cap_eff > 32'(MAX_ENTRIES)) begin
         cap_eff = 32'(MAX_ENTRIES);
      end
   end

   assign full = (32'(count_ff) >= cap_eff);

   always_comb begin
      hit_idx    = '0;
      hit_rank   = '0;
      victim_idx = '0;
      free_idx   = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         match[i]  = valid_ff[i] && (entry_key_ff[i] == key_ff);
         victim[i] = valid_ff[i] && (rank_ff[i] == last_rank);
         if (match[i]) begin
            hit_idx  = hit_idx | IDX_W'(i);
            hit_rank = hit_rank | rank_ff[i];
         end
         if (victim[i]) begin
            victim_idx = victim_idx | IDX_W'(i);
         end
      end
      for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = IDX_W'(i);
         end
      end
   end

   assign do_insert = !hit_ff && (act_ff == ACT_STORE);
   assign evict     = do_insert && full_ff;

   always_comb begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         valid_in[i] = valid_ff[i];
         rank_in[i]  = rank_ff[i];
         if (cmd.commit) begin
            if (hit_ff) begin
               if (hit_idx_ff == IDX_W'(i)) begin
                  rank_in[i] = '0;
               end else if (valid_ff[i] && (rank_ff[i] < hit_rank_ff)) begin
                  rank_in[i] = rank_ff[i] + IDX_W'(1);
               end
            end else if (do_insert) begin
               if (slot_idx_ff == IDX_W'(i)) begin
                  valid_in[i] = 1'b1;
                  rank_in[i]  = '0;
               end else if (valid_ff[i]) begin
                  rank_in[i] = rank_ff[i] + IDX_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            valid_ff[i] <= 1'b0;
            rank_ff[i]  <= '0;
         end
         count_ff     <= '0;
         capacity_ff  <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            valid_ff[i] <= valid_in[i];
            rank_ff[i]  <= rank_in[i];
         end
         if (csr_valid) begin
            capacity_ff <= csr_data;
         end
         if (cmd.commit && do_insert && !full_ff) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff <= req_payload.action;
         key_ff <= req_payload.lookup_key[KEY_W-1:0];
         val_ff <= req_payload.store_value[VAL_W-1:0];
      end
      if (cmd.compare) begin
         hit_ff      <= |match;
         hit_idx_ff  <= hit_idx;
         hit_rank_ff <= hit_rank;
         slot_idx_ff <= full ? victim_idx : free_idx;
         full_ff     <= full;
      end
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (cmd.commit && do_insert && (slot_idx_ff == IDX_W'(i))) begin
            entry_key_ff[i] <= key_ff;
         end
      end
      if (cmd.commit) begin
         rsp_data_ff.hit         <= hit_ff;
         rsp_data_ff.read_value  <= (hit_ff && (act_ff == ACT_LOOKUP))
                                    ? VALUE_FIELD_W'(val_rdata) : '0;
         rsp_data_ff.evicted     <= evict;
         rsp_data_ff.evicted_key <= evict ? KEY_FIELD_W'(key_rdata) : '0;
      end
   end

   lkv_ram #(
      .WIDTH (VAL_W),
      .DEPTH (MAX_ENTRIES)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (cmd.commit && (act_ff == ACT_STORE)),
      .wr_addr (hit_ff ? hit_idx_ff : slot_idx_ff),
      .wr_data (val_ff),
      .rd_en   (cmd.read),
      .rd_addr (hit_idx_ff),
      .rd_data (val_rdata)
   );

   lkv_ram #(
      .WIDTH (KEY_W),
      .DEPTH (MAX_ENTRIES)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (cmd.commit && do_insert),
      .wr_addr (slot_idx_ff),
      .wr_data (key_ff),
      .rd_en   (cmd.read),
      .rd_addr (slot_idx_ff),
      .rd_data (key_rdata)
   );

   assign status.rsp_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_payload     = rsp_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/lkv_checker.sv
// lkv_checker: port-level assertions for lru_key_value_cache_top, bound in.
// Depends on lkv_pkg and the top level's port list.
`default_nettype none

module lkv_checker
   import lkv_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire rsp_type          rsp_payload
);

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("outputs not idle after reset");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##4 rsp_valid)
      else $error("no result after request");

   a_evict_on_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.evicted |-> !rsp_payload.hit
         && (rsp_payload.read_value == '0))
      else $error("eviction reported with hit or read data");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled transaction changed");

endmodule

bind lru_key_value_cache_top lkv_checker u_checker (.*);

`default_nettype wire
